>>> rtl/tppc_pkg.sv
// Shared types and constants for the two-probe pump controller.
// Used by tppc_datapath, tppc_ctrl and the top level; depends on nothing.
package tppc_pkg;

   localparam int REG_W   = 32;   // widest configuration register
   localparam int IDX_W   = 3;    // configuration register index
   localparam int PCT_W   = 7;
   localparam int TIME_W  = 32;
   localparam int EV_W    = 3;
   localparam int PCT_MAX = 100;

   localparam int DRY_THR_RST   = 55;
   localparam int WET_THR_RST   = 40;
   localparam int MAX_RUN_RST   = 15000;
   localparam int MIN_REST_RST  = 10000;
   localparam int DRY_CAL_A_RST = 900;
   localparam int WET_CAL_A_RST = 300;
   localparam int DRY_CAL_B_RST = 880;
   localparam int WET_CAL_B_RST = 320;

   typedef enum logic [IDX_W-1:0] {
      REG_DRY_THR   = 3'd0,
      REG_WET_THR   = 3'd1,
      REG_MAX_RUN   = 3'd2,
      REG_MIN_REST  = 3'd3,
      REG_DRY_CAL_A = 3'd4,
      REG_WET_CAL_A = 3'd5,
      REG_DRY_CAL_B = 3'd6,
      REG_WET_CAL_B = 3'd7
   } reg_index_type;

   typedef enum logic [EV_W-1:0] {
      EV_NONE     = 3'd0,
      EV_AUTO     = 3'd1,
      EV_BLOCKED  = 3'd2,
      EV_WET_STOP = 3'd3,
      EV_SAFETY   = 3'd4,
      EV_OVERRIDE = 3'd5
   } event_type;

   // which quotient the shared divider is working on
   typedef enum logic [1:0] {
      SEL_AVG_A = 2'd0,
      SEL_PCT_A = 2'd1,
      SEL_AVG_B = 2'd2,
      SEL_PCT_B = 2'd3
   } div_sel_type;

   typedef struct packed {
      logic        capture;    // take the item, read both rings
      logic        update;     // update sums and rings
      logic        div_start;
      div_sel_type div_sel;
      logic        div_latch;  // store the divider result
      logic        commit;     // pump decision and result register load
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

>>> rtl/tppc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module tppc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/tppc_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
// No dependencies; quotient and done are registered.
module tppc_div #(
   parameter int N = 17,   // dividend width
   parameter int D = 10    // divisor width
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic [N-1:0] quotient,
   output logic         done
);

   localparam int STEPS = (N + 1) / 2;
   localparam int NP    = 2 * STEPS;
   localparam int CW    = $clog2(STEPS + 1);

   logic [D:0]    rem_ff, rem_in;
   logic [NP-1:0] quo_ff, quo_in;
   logic [D-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   always_comb begin
      logic [D:0]    r;
      logic [NP-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int k = 0; k < 2; k++) begin
         r = {r[D-1:0], q[NP-1]};
         q = {q[NP-2:0], 1'b0};
         if (r >= {1'b0, dvs_ff}) begin
            r    = r - {1'b0, dvs_ff};
            q[0] = 1'b1;
         end
      end

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = NP'(dividend);
         dvs_in  = divisor;
         cnt_in  = CW'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = r;
         quo_in = q;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff[N-1:0];
   assign done     = done_ff;

endmodule

>>> rtl/tppc_datapath.sv
// Datapath: configuration registers, sample rings, running sums, shared
// divider, percent mapping and pump decision. Uses tppc_pkg, tppc_ram, tppc_div.
module tppc_datapath #(
   parameter int TAPS        = 10,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tppc_pkg::dp_cmd_type               cmd,
   output tppc_pkg::dp_status_type            status,
   input  logic [SAMPLE_BITS-1:0]             req_sample_a,
   input  logic [SAMPLE_BITS-1:0]             req_sample_b,
   input  logic                               req_override_pressed,
   input  logic [tppc_pkg::TIME_W-1:0]        req_now_ms,
   input  logic                               csr_we,
   input  logic [tppc_pkg::IDX_W-1:0]         csr_index,
   input  logic [tppc_pkg::REG_W-1:0]         csr_wdata,
   output logic                               rsp_pump_on,
   output logic [tppc_pkg::PCT_W-1:0]         rsp_percent_a,
   output logic [tppc_pkg::PCT_W-1:0]         rsp_percent_b,
   output logic [tppc_pkg::EV_W-1:0]          rsp_event_res
);

   localparam int SB    = SAMPLE_BITS;
   localparam int PW    = $clog2(TAPS);
   localparam int SUM_W = SB + $clog2(TAPS);
   localparam int NUM_W = SB + 7;   // |avg - wet| * 100
   localparam int TC_W  = $clog2(TAPS + 1);
   localparam int DVS_W = (SB > TC_W) ? SB : TC_W;
   localparam int PCT_W = tppc_pkg::PCT_W;
   localparam int TW    = tppc_pkg::TIME_W;

   // configuration
   logic [PCT_W-1:0] dry_thr_ff, wet_thr_ff;
   logic [TW-1:0]    max_run_ff, min_rest_ff;
   logic [SB-1:0]    dry_cal_a_ff, wet_cal_a_ff, dry_cal_b_ff, wet_cal_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dry_thr_ff   <= PCT_W'(tppc_pkg::DRY_THR_RST);
         wet_thr_ff   <= PCT_W'(tppc_pkg::WET_THR_RST);
         max_run_ff   <= TW'(tppc_pkg::MAX_RUN_RST);
         min_rest_ff  <= TW'(tppc_pkg::MIN_REST_RST);
         dry_cal_a_ff <= SB'(tppc_pkg::DRY_CAL_A_RST);
         wet_cal_a_ff <= SB'(tppc_pkg::WET_CAL_A_RST);
         dry_cal_b_ff <= SB'(tppc_pkg::DRY_CAL_B_RST);
         wet_cal_b_ff <= SB'(tppc_pkg::WET_CAL_B_RST);
      end else if (csr_we) begin
         unique case (tppc_pkg::reg_index_type'(csr_index))
            tppc_pkg::REG_DRY_THR:   dry_thr_ff   <= csr_wdata[PCT_W-1:0];
            tppc_pkg::REG_WET_THR:   wet_thr_ff   <= csr_wdata[PCT_W-1:0];
            tppc_pkg::REG_MAX_RUN:   max_run_ff   <= csr_wdata[TW-1:0];
            tppc_pkg::REG_MIN_REST:  min_rest_ff  <= csr_wdata[TW-1:0];
            tppc_pkg::REG_DRY_CAL_A: dry_cal_a_ff <= csr_wdata[SB-1:0];
            tppc_pkg::REG_WET_CAL_A: wet_cal_a_ff <= csr_wdata[SB-1:0];
            tppc_pkg::REG_DRY_CAL_B: dry_cal_b_ff <= csr_wdata[SB-1:0];
            tppc_pkg::REG_WET_CAL_B: wet_cal_b_ff <= csr_wdata[SB-1:0];
         endcase
      end
   end

   // captured item
   logic [SB-1:0] sa_ff, sb_ff;
   logic          ovr_ff;
   logic [TW-1:0] now_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sa_ff  <= req_sample_a;
         sb_ff  <= req_sample_b;
         ovr_ff <= req_override_pressed;
         now_ff <= req_now_ms;
      end
   end

   // rings and running sums
   logic [PW-1:0]    pos_ff, pos_in;
   logic [TAPS-1:0]  fill_ff;          // entry written since reset
   logic [SUM_W-1:0] sum_a_ff, sum_b_ff, sum_a_in, sum_b_in;
   logic [SB-1:0]    ring_a_rd, ring_b_rd, old_a, old_b;

   tppc_ram #(.WIDTH(SB), .DEPTH(TAPS)) u_ring_a (
      .clock (clock),
      .we    (cmd.update),
      .waddr (pos_ff),
      .wdata (sa_ff),
      .re    (cmd.capture),
      .raddr (pos_ff),
      .rdata (ring_a_rd)
   );

   tppc_ram #(.WIDTH(SB), .DEPTH(TAPS)) u_ring_b (
      .clock (clock),
      .we    (cmd.update),
      .waddr (pos_ff),
      .wdata (sb_ff),
      .re    (cmd.capture),
      .raddr (pos_ff),
      .rdata (ring_b_rd)
   );

   always_comb begin
      old_a    = fill_ff[pos_ff] ? ring_a_rd : '0;
      old_b    = fill_ff[pos_ff] ? ring_b_rd : '0;
      sum_a_in = sum_a_ff - SUM_W'(old_a) + SUM_W'(sa_ff);
      sum_b_in = sum_b_ff - SUM_W'(old_b) + SUM_W'(sb_ff);
      pos_in   = (pos_ff == PW'(TAPS - 1)) ? '0 : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         fill_ff  <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
      end else if (cmd.update) begin
         pos_ff          <= pos_in;
         fill_ff[pos_ff] <= 1'b1;
         sum_a_ff        <= sum_a_in;
         sum_b_ff        <= sum_b_in;
      end
   end

   // divider operands
   logic [SB-1:0]    avg_ff, sel_wet, sel_dry;
   logic [SUM_W-1:0] sel_sum;
   logic [SB:0]      diff, den;
   logic [SB-1:0]    diff_mag, den_mag;
   logic             pct_zero;
   logic [NUM_W-1:0] num, dividend, quotient;
   logic [DVS_W-1:0] divisor;
   logic             is_avg;
   logic [PCT_W-1:0] pct;
   logic [PCT_W-1:0] pa_ff, pb_ff;

   always_comb begin
      is_avg = (cmd.div_sel == tppc_pkg::SEL_AVG_A) || (cmd.div_sel == tppc_pkg::SEL_AVG_B);
      if ((cmd.div_sel == tppc_pkg::SEL_AVG_A) || (cmd.div_sel == tppc_pkg::SEL_PCT_A)) begin
         sel_sum = sum_a_ff;
         sel_wet = wet_cal_a_ff;
         sel_dry = dry_cal_a_ff;
      end else begin
         sel_sum = sum_b_ff;
         sel_wet = wet_cal_b_ff;
         sel_dry = dry_cal_b_ff;
      end
      diff     = {1'b0, avg_ff} - {1'b0, sel_wet};
      den      = {1'b0, sel_dry} - {1'b0, sel_wet};
      diff_mag = diff[SB] ? SB'(~diff + 1'b1) : diff[SB-1:0];
      den_mag  = den[SB] ? SB'(~den + 1'b1) : den[SB-1:0];
      // opposite signs truncate to zero or below, equal calibrations read zero
      pct_zero = (den == '0) || (diff[SB] != den[SB]);
      num      = NUM_W'(diff_mag) * NUM_W'(tppc_pkg::PCT_MAX);
      dividend = is_avg ? NUM_W'(sel_sum) : num;
      divisor  = is_avg ? DVS_W'(TAPS) : DVS_W'(den_mag);
      if (pct_zero) begin
         pct = '0;
      end else if (quotient > NUM_W'(tppc_pkg::PCT_MAX)) begin
         pct = PCT_W'(tppc_pkg::PCT_MAX);
      end else begin
         pct = quotient[PCT_W-1:0];
      end
   end

   tppc_div #(.N(NUM_W), .D(DVS_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (status.div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_latch) begin
         unique case (cmd.div_sel)
            tppc_pkg::SEL_AVG_A,
            tppc_pkg::SEL_AVG_B: avg_ff <= quotient[SB-1:0];
            tppc_pkg::SEL_PCT_A: pa_ff  <= pct;
            tppc_pkg::SEL_PCT_B: pb_ff  <= pct;
         endcase
      end
   end

   // pump decision
   logic                running_ff, running_in;
   logic [TW-1:0]       start_ff, start_in, stop_ff, stop_in;
   logic [TW-1:0]       rest_gap, run_gap;
   logic                dry, wet, started;
   tppc_pkg::event_type ev;

   always_comb begin
      rest_gap   = now_ff - stop_ff;
      run_gap    = now_ff - start_ff;
      dry        = (pa_ff > dry_thr_ff) || (pb_ff > dry_thr_ff);
      wet        = (pa_ff < wet_thr_ff) && (pb_ff < wet_thr_ff);
      running_in = running_ff;
      start_in   = start_ff;
      stop_in    = stop_ff;
      started    = 1'b0;
      ev         = tppc_pkg::EV_NONE;
      if (ovr_ff) begin
         running_in = 1'b1;
         start_in   = now_ff;
         ev         = tppc_pkg::EV_OVERRIDE;
      end else begin
         if (dry && !running_ff) begin
            if (rest_gap > min_rest_ff) begin
               running_in = 1'b1;
               start_in   = now_ff;
               started    = 1'b1;
               ev         = tppc_pkg::EV_AUTO;
            end else begin
               ev = tppc_pkg::EV_BLOCKED;
            end
         end
         if (wet && running_in) begin
            running_in = 1'b0;
            stop_in    = now_ff;
            ev         = tppc_pkg::EV_WET_STOP;
         end
         // a start in this step leaves a zero run time
         if (running_in && !started && (run_gap > max_run_ff)) begin
            running_in = 1'b0;
            stop_in    = now_ff;
            ev         = tppc_pkg::EV_SAFETY;
         end
      end
   end

   logic [PCT_W-1:0]              out_pa_ff, out_pb_ff;
   logic [tppc_pkg::EV_W-1:0]     out_ev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         start_ff   <= '0;
         stop_ff    <= '0;
      end else if (cmd.commit) begin
         running_ff <= running_in;
         start_ff   <= start_in;
         stop_ff    <= stop_in;
      end
      if (cmd.commit) begin
         out_pa_ff <= pa_ff;
         out_pb_ff <= pb_ff;
         out_ev_ff <= ev;
      end
   end

   assign rsp_pump_on   = running_ff;
   assign rsp_percent_a = out_pa_ff;
   assign rsp_percent_b = out_pb_ff;
   assign rsp_event_res = out_ev_ff;

endmodule

>>> rtl/tppc_ctrl.sv
// Sequencer for one item: ring update, four divisions, decision and
// result handshake. Uses tppc_pkg for the command and status structs.
module tppc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tppc_pkg::dp_cmd_type    cmd,
   input  tppc_pkg::dp_status_type status
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_UPDATE = 7'b0000010,
      S_AVG_A  = 7'b0000100,
      S_PCT_A  = 7'b0001000,
      S_AVG_B  = 7'b0010000,
      S_PCT_B  = 7'b0100000,
      S_COMMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      kick_ff, kick_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      kick_in       = 1'b0;
      cmd           = '0;
      cmd.div_sel   = tppc_pkg::SEL_AVG_A;
      cmd.div_start = kick_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.div_start = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.div_start = 1'b0;
            cmd.update    = 1'b1;
            kick_in       = 1'b1;
            state_in      = S_AVG_A;
         end
         S_AVG_A: begin
            cmd.div_sel = tppc_pkg::SEL_AVG_A;
            if (status.div_done) begin
               cmd.div_latch = 1'b1;
               kick_in       = 1'b1;
               state_in      = S_PCT_A;
            end
         end
         S_PCT_A: begin
            cmd.div_sel = tppc_pkg::SEL_PCT_A;
            if (status.div_done) begin
               cmd.div_latch = 1'b1;
               kick_in       = 1'b1;
               state_in      = S_AVG_B;
            end
         end
         S_AVG_B: begin
            cmd.div_sel = tppc_pkg::SEL_AVG_B;
            if (status.div_done) begin
               cmd.div_latch = 1'b1;
               kick_in       = 1'b1;
               state_in      = S_PCT_B;
            end
         end
         S_PCT_B: begin
            cmd.div_sel = tppc_pkg::SEL_PCT_B;
            if (status.div_done) begin
               cmd.div_latch = 1'b1;
               state_in      = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.div_start = 1'b0;
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            cmd.div_start = 1'b0;
            state_in      = S_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kick_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kick_ff      <= kick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while held");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("result valid without a commit");

   a_single_kick: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.div_start)
      else $error("divider started twice in a row");
`endif

endmodule

>>> rtl/two_probe_pump_controller.sv
// Two-probe pump controller: moving average, calibrated percent and pump
// control for two moisture probes, one sample period per item.
//
// Input channel (req_): one item holds both raw samples, the override button
// and the millisecond timestamp; it is taken when req_valid is high and
// req_stall is low. Result channel (rsp_): one item per input, pump state,
// both percents and the event code, held in an output register until taken
// (rsp_valid high, rsp_stall low). Configuration (csr_): write enable, index
// and data; write only while no item is in flight.
// Timing: an item runs through one ring update and four divisions on a
// shared two-bit-per-cycle divider, then the pump decision and the result
// register load. One item at a time: a new item is taken only once the one
// before it has been committed to the output register. A stalled result
// holds the item after it in its final step until the output register
// frees. Reset (synchronous) clears sums, timers and the pump, marks the
// rings empty, and loads the default thresholds and calibrations.
// Uses tppc_pkg, tppc_ctrl and tppc_datapath.
module two_probe_pump_controller #(
   parameter int TAPS        = 10,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [SAMPLE_BITS-1:0]      req_sample_a,
   input  logic [SAMPLE_BITS-1:0]      req_sample_b,
   input  logic                        req_override_pressed,
   input  logic [tppc_pkg::TIME_W-1:0] req_now_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_pump_on,
   output logic [tppc_pkg::PCT_W-1:0]  rsp_percent_a,
   output logic [tppc_pkg::PCT_W-1:0]  rsp_percent_b,
   output logic [tppc_pkg::EV_W-1:0]   rsp_event_res,
   input  logic                        csr_we,
   input  logic [tppc_pkg::IDX_W-1:0]  csr_index,
   input  logic [tppc_pkg::REG_W-1:0]  csr_wdata
);

   tppc_pkg::dp_cmd_type    cmd;
   tppc_pkg::dp_status_type status;

   tppc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tppc_datapath #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_sample_a         (req_sample_a),
      .req_sample_b         (req_sample_b),
      .req_override_pressed (req_override_pressed),
      .req_now_ms           (req_now_ms),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_pump_on          (rsp_pump_on),
      .rsp_percent_a        (rsp_percent_a),
      .rsp_percent_b        (rsp_percent_b),
      .rsp_event_res        (rsp_event_res)
   );

endmodule
